@@ rtl/core/srom_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Season row overlap merge package
// Shared row and result record types, register map and fixed constants.
// ----------------------------------------------------------------------------
package srom_pkg;

	// One season row: three day numbers and three signed Q15.16 values.
	typedef struct packed {
		logic signed [31:0] value_end;
		logic signed [31:0] value_peak;
		logic signed [31:0] value_begin;
		logic        [15:0] day_end;
		logic        [15:0] day_peak;
		logic        [15:0] day_begin;
	} row_t;

	// One result record as it waits in the output queue.
	typedef struct packed {
		logic               burst_last;
		logic               table_end;
		logic               absorbed;
		logic signed [17:0] season_length;
		row_t               row;
	} result_t;

	// Register map, indexed by paddr[3:2].
	localparam logic [1:0] REG_MERGE_ENABLE      = 2'd0;
	localparam logic [1:0] REG_TROUGH_RATIO_MAX  = 2'd1;
	localparam logic [1:0] REG_AMPLITUDE_RATIO   = 2'd2;

	// Register reset values.
	localparam logic        MERGE_ENABLE_RST     = 1'b1;
	localparam logic [15:0] TROUGH_RATIO_MAX_RST = 16'd45875;
	localparam logic [15:0] AMP_RATIO_MIN_RST    = 16'd1311;

	// Extra 0.1 added to the amplitude ratio for the slope tests, in Q0.16.
	localparam logic [16:0] RATIO_EXTRA          = 17'd6554;

	// Day limits for close seasons.
	localparam logic signed [16:0] CLOSE_DAYS    = 17'sd150;
	localparam logic signed [16:0] SPAN_DAYS     = 17'sd650;

	// Peak value given to an absorbed row: -9999.0 in Q15.16.
	localparam logic signed [31:0] PEAK_SENTINEL = -32'sd655294464;

	// Width of the threshold products and shifted heights.
	localparam int PROD_W = 54;

endpackage

@@ rtl/core/season_row_overlap_merge_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Season row overlap merge core
// Holds one pending season row, compares it with each new row, cuts
// overlapping seasons, pushes back low second seasons and merges close ones.
// ----------------------------------------------------------------------------
// A row taken on the slave side is registered in the input register,
// compared there with the pending row, and the result words of that compare
// go into the output queue that drives the master side. Throughput: one row
// per cycle while the four-word output queue has at least two free slots;
// otherwise the compare stage waits. Reset clears the pending row, the queue and the
// input register, and loads the register reset values.
module season_row_overlap_merge_core
	import srom_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// day_begin[15:0], day_peak[31:16], day_end[47:32], value_begin[79:48],
	// value_peak[111:80], value_end[143:112]
	input  logic [143:0] s_tdata,
	input  logic         s_tlast,     // in_last_row
	// Master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// day_begin[15:0], day_peak[31:16], day_end[47:32], value_begin[79:48],
	// value_peak[111:80], value_end[143:112], season_length[161:144], zeros
	output logic [167:0] m_tdata,
	output logic [1:0]   m_tuser,     // absorbed[0], burst_last[1]
	output logic         m_tlast,     // table_end
	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic        merge_enable_q;
	logic [15:0] trough_ratio_max_q;
	logic [15:0] amp_ratio_min_q;
	logic [16:0] amp_ratio_extra_q;   // amp_ratio_min + 0.1, kept ready
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_enable_q     <= MERGE_ENABLE_RST;
			trough_ratio_max_q <= TROUGH_RATIO_MAX_RST;
			amp_ratio_min_q    <= AMP_RATIO_MIN_RST;
			amp_ratio_extra_q  <= 17'(AMP_RATIO_MIN_RST) + RATIO_EXTRA;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MERGE_ENABLE: begin
					merge_enable_q <= pwdata[0];
				end
				REG_TROUGH_RATIO_MAX: begin
					trough_ratio_max_q <= pwdata[15:0];
				end
				REG_AMPLITUDE_RATIO: begin
					amp_ratio_min_q   <= pwdata[15:0];
					amp_ratio_extra_q <= 17'(pwdata[15:0]) + RATIO_EXTRA;
				end
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_MERGE_ENABLE:     prdata = {31'd0, merge_enable_q};
			REG_TROUGH_RATIO_MAX: prdata = {16'd0, trough_ratio_max_q};
			REG_AMPLITUDE_RATIO:  prdata = {16'd0, amp_ratio_min_q};
			default:              prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic       valid_s1;
	row_t       row_s1;
	logic       last_s1;
	logic       fire;
	logic [CNT_W-1:0] count_q;

	assign fire     = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			row_s1  <= row_t'(s_tdata);
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Pending row
	// ------------------------------------------------------------------
	logic pending_valid_q;
	row_t pending_q;

	// ------------------------------------------------------------------
	// Compare pending row (a) with new row (b)
	// ------------------------------------------------------------------
	row_t a, b;
	logic signed [16:0] t_diff, span;
	logic signed [31:0] t1min, t2min, tmin, vpmax;
	logic signed [32:0] amp, h2l, h1r, h1_peak, h2_peak, h1_trough;
	logic signed [PROD_W-1:0] thr, thr2, thr_high;
	logic signed [48:0] h2l_sh, h1r_sh, h1p_sh, h2p_sh, h1t_sh;
	logic small1, small2, pre_end_smaller;
	logic merge_win, left_slope_merge, right_slope_merge, high, do_merge;

	always_comb begin
		a = pending_q;
		b = row_s1;

		t_diff = $signed({1'b0, row_s1.day_begin}) - $signed({1'b0, pending_q.day_end});
		span   = $signed({1'b0, row_s1.day_end}) - $signed({1'b0, pending_q.day_begin});

		// Amplitude over both seasons.
		t1min = (pending_q.value_begin < pending_q.value_end) ?
			pending_q.value_begin : pending_q.value_end;
		t2min = (row_s1.value_begin < row_s1.value_end) ?
			row_s1.value_begin : row_s1.value_end;
		tmin  = (t1min < t2min) ? t1min : t2min;
		vpmax = (pending_q.value_peak > row_s1.value_peak) ?
			pending_q.value_peak : row_s1.value_peak;
		amp   = 33'(vpmax) - 33'(tmin);

		// Thresholds: amplitude times Q0.16 ratios.
		thr      = PROD_W'(amp) * PROD_W'($signed({1'b0, amp_ratio_min_q}));
		thr2     = PROD_W'(amp) * PROD_W'($signed({1'b0, amp_ratio_extra_q}));
		thr_high = PROD_W'(amp) * PROD_W'($signed({1'b0, trough_ratio_max_q}));

		// Heights, scaled by one in Q0.16.
		h2l       = 33'(row_s1.value_peak) - 33'(row_s1.value_begin);
		h1r       = 33'(pending_q.value_peak) - 33'(pending_q.value_end);
		h1_peak   = 33'(pending_q.value_peak) - 33'(t1min);
		h2_peak   = 33'(row_s1.value_peak) - 33'(t2min);
		h1_trough = 33'(pending_q.value_end) - 33'(t1min);
		h2l_sh    = $signed({h2l, 16'h0000});
		h1r_sh    = $signed({h1r, 16'h0000});
		h1p_sh    = $signed({h1_peak, 16'h0000});
		h2p_sh    = $signed({h2_peak, 16'h0000});
		h1t_sh    = $signed({h1_trough, 16'h0000});

		small1 = PROD_W'(h1r_sh) <= thr;
		small2 = PROD_W'(h2l_sh) <= thr;
		pre_end_smaller = pending_q.value_end <= row_s1.value_begin;

		// Overlapping seasons are cut at the lower trough.
		if (t_diff < 17'sd0) begin
			if (pre_end_smaller) begin
				b.day_begin   = pending_q.day_end;
				b.value_begin = pending_q.value_end;
			end else begin
				a.day_end   = row_s1.day_begin;
				a.value_end = row_s1.value_begin;
			end
		end

		// A low second season is pushed back to the earlier begin.
		if (t_diff > 17'sd0 && t_diff <= CLOSE_DAYS && small2 &&
			pending_q.value_end < row_s1.value_begin) begin
			b.value_begin = pending_q.value_begin;
			b.day_begin   = pending_q.day_begin;
		end

		// Merge tests for close seasons.
		merge_win = merge_enable_q && t_diff >= 17'sd0 && t_diff <= CLOSE_DAYS &&
			span <= SPAN_DAYS;
		left_slope_merge  = small1 && (a.value_begin < b.value_begin) &&
			(PROD_W'(h1p_sh) > thr2);
		right_slope_merge = small2 && (a.value_end > b.value_end) &&
			(PROD_W'(h2p_sh) > thr2);
		high      = PROD_W'(h1t_sh) >= thr_high;
		do_merge  = pending_valid_q && merge_win &&
			(high || left_slope_merge || right_slope_merge);

		if (do_merge) begin
			a.value_end = b.value_end;
			a.day_end   = b.day_end;
			if (a.value_peak < b.value_peak) begin
				a.day_peak   = b.day_peak;
				a.value_peak = b.value_peak;
			end
			b.value_peak = PEAK_SENTINEL;
		end

		// Without a pending row the new row is taken as it came.
		if (!pending_valid_q) begin
			b = row_s1;
		end
	end

	// ------------------------------------------------------------------
	// Result words for this row
	// ------------------------------------------------------------------
	function automatic result_t make_result(row_t r, logic absorbed, logic tend,
		logic blast);
		result_t res;
		res.row           = r;
		res.season_length = $signed({2'b00, r.day_end}) - $signed({2'b00, r.day_begin})
			+ 18'sd1;
		res.absorbed      = absorbed;
		res.table_end     = tend;
		res.burst_last    = blast;
		return res;
	endfunction

	result_t    res0, res1;
	logic [1:0] n_push;
	logic       pending_set, pending_clear;

	always_comb begin
		res0          = make_result(b, 1'b0, 1'b1, 1'b1);
		res1          = make_result(b, 1'b0, 1'b1, 1'b1);
		n_push        = 2'd0;
		pending_set   = 1'b0;
		pending_clear = 1'b0;
		if (pending_valid_q) begin
			if (do_merge) begin
				res0          = make_result(a, 1'b0, 1'b0, 1'b0);
				res1          = make_result(b, 1'b1, last_s1, 1'b1);
				n_push        = 2'd2;
				pending_clear = 1'b1;
			end else begin
				res0 = make_result(a, 1'b0, 1'b0, !last_s1);
				if (last_s1) begin
					n_push        = 2'd2;
					pending_clear = 1'b1;
				end else begin
					n_push      = 2'd1;
					pending_set = 1'b1;
				end
			end
		end else if (last_s1) begin
			n_push        = 2'd1;
			pending_clear = 1'b1;
		end else begin
			pending_set = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
		end else if (fire) begin
			if (pending_clear) begin
				pending_valid_q <= 1'b0;
			end else if (pending_set) begin
				pending_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pending_set) begin
			pending_q <= b;
		end
	end

	// ------------------------------------------------------------------
	// Output queue: up to two words in and, while m_tready is high, one word out per cycle
	// ------------------------------------------------------------------
	result_t          queue_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_next;
	logic             pop;
	logic [1:0]       n_in;
	result_t          head;

	assign n_in        = fire ? n_push : 2'd0;
	assign wr_ptr_next = wr_ptr_q + PTR_W'(1);
	assign pop         = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_in) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_in == 2'd2) begin
			queue_q[wr_ptr_next] <= res1;
		end
	end

	// Master side driven from the queue head.
	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = count_q != '0;
	assign m_tdata  = {6'd0, head.season_length, head.row};
	assign m_tuser  = {head.burst_last, head.absorbed};
	assign m_tlast  = head.table_end;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Season row overlap merge core testbench
// Streams season tables into the core under changing register settings and
// handshake pressure. A built-in predictor cuts, pushes back and merges rows
// the way the core should. Every result word is checked field by field
// against the oldest predicted row.
// ----------------------------------------------------------------------------
module tb;
	import srom_pkg::*;

	// Predictor constants.
	localparam longint CLOSE_GAP     = 150;
	localparam longint SPAN_MAX      = 650;
	localparam longint SLOPE_EXTRA   = 6554;
	localparam longint Q16_UNIT      = 65536;
	localparam logic signed [31:0] ABSORBED_PEAK = -32'sd655294464;

	// Index past the end of the register map; writes to it must be ignored.
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int PHASE_ROWS     = 305;
	localparam int PHASE_COUNT    = 6;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;

	// One row waiting to be sent, with its table end flag.
	typedef struct {
		row_t row;
		bit   last;
		bit   drain;   // hold the row back until every result has come
	} season_item_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [167:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	season_item_t season_q[$];
	result_t      season_result_q[$];

	// Predictor copy of the registers and of the pending row.
	bit           cfg_merge;
	logic [15:0]  cfg_trough;
	logic [15:0]  cfg_amp;
	bit           held_valid;
	row_t         held_row;

	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  row_taken;
	int  rows_queued;
	int  rows_accepted;
	int  results_seen;
	int  absorbed_seen;
	int  tables_seen;
	int  cfg_writes;
	int  err_count;
	int  quiet_cycles;

	season_row_overlap_merge_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Compare an earlier row a with a later row b, correcting both in place.
	// Returns 1 when b is merged into a.
	function automatic bit compare_seasons(inout row_t a, inout row_t b);
		longint adb, adp, ade, avb, avp, ave;
		longint bdb, bdp, bde, bvb, bvp, bve;
		longint t_diff, span, t1min, t2min, amp, h2l, h1r, thr, thr2;
		bit small1, small2, pre_end_smaller, left_slope_merge, right_slope_merge;
		bit high_trough;
		adb = a.day_begin;   adp = a.day_peak;   ade = a.day_end;
		avb = a.value_begin; avp = a.value_peak; ave = a.value_end;
		bdb = b.day_begin;   bdp = b.day_peak;   bde = b.day_end;
		bvb = b.value_begin; bvp = b.value_peak; bve = b.value_end;

		t_diff = bdb - ade;
		span   = bde - adb;
		t1min  = (avb < ave) ? avb : ave;
		t2min  = (bvb < bve) ? bvb : bve;
		amp    = ((avp > bvp) ? avp : bvp) - ((t1min < t2min) ? t1min : t2min);
		h2l    = bvp - bvb;
		h1r    = avp - ave;
		thr    = amp * longint'(cfg_amp);
		thr2   = amp * (longint'(cfg_amp) + SLOPE_EXTRA);
		small1 = h1r * Q16_UNIT <= thr;
		small2 = h2l * Q16_UNIT <= thr;
		pre_end_smaller = ave <= bvb;

		// Overlapping seasons are cut at the lower trough between them.
		if (t_diff < 0) begin
			if (pre_end_smaller) begin
				bdb = ade;
				bvb = ave;
			end else begin
				ade = bdb;
				ave = bvb;
			end
		end
		// A second season that rises little on its left starts at the first begin.
		if (t_diff > 0 && t_diff <= CLOSE_GAP && small2 && ave < bvb) begin
			bvb = avb;
			bdb = adb;
		end

		a.day_end = 16'(ade);
		a.value_end = 32'(ave);
		b.day_begin = 16'(bdb);
		b.value_begin = 32'(bvb);

		if (!(cfg_merge && t_diff >= 0 && t_diff <= CLOSE_GAP && span <= SPAN_MAX))
			return 1'b0;
		left_slope_merge  = small1 && avb < bvb && (avp - t1min) * Q16_UNIT > thr2;
		right_slope_merge = small2 && ave > bve && (bvp - t2min) * Q16_UNIT > thr2;
		high_trough = (ave - t1min) * Q16_UNIT >= amp * longint'(cfg_trough);
		if (!(high_trough || left_slope_merge || right_slope_merge))
			return 1'b0;

		// Merge: the earlier row takes the later end and the higher peak.
		a.day_end = b.day_end;
		a.value_end = b.value_end;
		if (avp < bvp) begin
			a.day_peak = b.day_peak;
			a.value_peak = b.value_peak;
		end
		b.value_peak = ABSORBED_PEAK;
		return 1'b1;
	endfunction

	function automatic void push_result(row_t r, bit absorbed, bit table_end, bit burst_last);
		result_t res;
		longint len;
		len = longint'(r.day_end) - longint'(r.day_begin) + 1;
		res.row = r;
		res.season_length = 18'(len);
		res.absorbed = absorbed;
		res.table_end = table_end;
		res.burst_last = burst_last;
		season_result_q.push_back(res);
	endfunction

	// Work out the result words caused by one accepted row.
	function automatic void predict_season_row(row_t new_row, bit last);
		row_t prev;
		prev = held_row;
		if (held_valid) begin
			if (compare_seasons(prev, new_row)) begin
				push_result(prev, 1'b0, 1'b0, 1'b0);
				push_result(new_row, 1'b1, last, 1'b1);
				held_valid = 1'b0;
				return;
			end
			push_result(prev, 1'b0, 1'b0, !last);
		end
		if (last) begin
			push_result(new_row, 1'b0, 1'b1, 1'b1);
			held_valid = 1'b0;
		end else begin
			held_valid = 1'b1;
			held_row = new_row;
		end
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic check_result();
		result_t want;
		row_t    got;
		got = m_tdata[143:0];
		if (season_result_q.size() == 0) begin
			$error("result word with no row expected: day_begin %0d", got.day_begin);
			err_count++;
			return;
		end
		want = season_result_q.pop_front();
		check_field("day_begin", want.row.day_begin, got.day_begin);
		check_field("day_peak", want.row.day_peak, got.day_peak);
		check_field("day_end", want.row.day_end, got.day_end);
		check_field("value_begin", want.row.value_begin, got.value_begin);
		check_field("value_peak", want.row.value_peak, got.value_peak);
		check_field("value_end", want.row.value_end, got.value_end);
		check_field("season_length", want.season_length, $signed(m_tdata[161:144]));
		check_field("tdata_padding", 0, m_tdata[167:162]);
		check_field("absorbed", want.absorbed, m_tuser[0]);
		check_field("burst_last", want.burst_last, m_tuser[1]);
		check_field("table_end", want.table_end, m_tlast);
	endtask

	// Sample both handshakes, predict accepted rows and check result words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_season_row(row_t'(s_tdata), s_tlast);
				row_taken = 1'b1;
				rows_accepted++;
			end
			if (m_tvalid && m_tready) begin
				check_result();
				results_seen++;
				absorbed_seen += m_tuser[0];
				tables_seen += m_tlast;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
				$display("[season_row_overlap_merge_core] ERROR");
				$finish;
			end
		end
	end

	// Drive the slave side from the row queue and stall the master side.
	always @(negedge clk) begin
		season_item_t item;
		logic next_valid;
		next_valid = s_tvalid;
		if (row_taken) begin
			next_valid = 1'b0;
			row_taken = 1'b0;
		end
		if (arst_n && !next_valid && season_q.size() != 0
				&& !(season_q[0].drain && season_result_q.size() != 0)
				&& $urandom_range(0, 99) >= tx_idle_pct) begin
			item = season_q.pop_front();
			s_tdata <= item.row;
			s_tlast <= item.last;
			next_valid = 1'b1;
		end
		s_tvalid <= next_valid;
		m_tready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	function automatic row_t season_row(input int db, input int dp, input int de,
			input int vb, input int vp, input int ve);
		row_t r;
		r.day_begin = 16'(db);
		r.day_peak = 16'(dp);
		r.day_end = 16'(de);
		r.value_begin = vb;
		r.value_peak = vp;
		r.value_end = ve;
		return r;
	endfunction

	task automatic queue_row(input row_t r, input bit last, input bit drain);
		season_item_t item;
		item.row = r;
		item.last = last;
		item.drain = drain;
		season_q.push_back(item);
		rows_queued++;
	endtask

	// A plausible season table: rising and falling seasons with small gaps,
	// some overlapping, some with high troughs or odd shapes.
	task automatic queue_season_table(input int n_rows);
		row_t r;
		int cursor, gap, base, height, dbeg, dpk, dend;
		cursor = $urandom_range(0, 60000);
		for (int i = 0; i < n_rows; i++) begin
			gap = int'($urandom_range(0, 260)) - 60;
			dbeg = cursor + gap;
			dpk = dbeg + int'($urandom_range(1, 120));
			dend = dpk + int'($urandom_range(1, 150));
			base = int'($urandom_range(0, 131072)) - 65536;
			height = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
				: $urandom_range(2000, 200000);
			r = season_row(dbeg, dpk, dend, 0, base + height, 0);
			case ($urandom_range(0, 3))
				0: r.value_begin = base + int'($urandom_range(0, height / 4));
				1: r.value_begin = base + height - int'($urandom_range(0, height / 8));
				default: r.value_begin = base + int'($urandom_range(0, height));
			endcase
			case ($urandom_range(0, 3))
				0: r.value_end = base + int'($urandom_range(0, height / 4));
				1: r.value_end = base + height - int'($urandom_range(0, height / 8));
				default: r.value_end = base + int'($urandom_range(0, height));
			endcase
			// Now and then a peak below its troughs or an end before the begin.
			if ($urandom_range(0, 19) == 0)
				r.value_peak = base - height;
			if ($urandom_range(0, 29) == 0) begin
				r.day_begin = 16'(dend);
				r.day_end = 16'(dbeg);
			end
			queue_row(r, i == n_rows - 1, $urandom_range(0, 59) == 0);
			cursor = dend;
		end
	endtask

	// Rows with every field random, table ends at random.
	task automatic queue_noise_rows(input int n_rows);
		for (int i = 0; i < n_rows; i++)
			queue_row(season_row($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom()), $urandom_range(0, 2) == 0, 1'b0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MERGE_ENABLE:     cfg_merge = value[0];
			REG_TROUGH_RATIO_MAX: cfg_trough = value[15:0];
			REG_AMPLITUDE_RATIO:  cfg_amp = value[15:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic set_ratios(input bit merge, input logic [15:0] trough,
			input logic [15:0] amp);
		write_reg(REG_MERGE_ENABLE, {31'd0, merge});
		write_reg(REG_TROUGH_RATIO_MAX, {16'd0, trough});
		write_reg(REG_AMPLITUDE_RATIO, {16'd0, amp});
	endtask

	// Wait until every queued row is in and every predicted word is out.
	task automatic wait_quiet();
		while (rows_accepted != rows_queued || season_result_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int phase_rows, n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_merge = MERGE_ENABLE_RST;
		cfg_trough = TROUGH_RATIO_MAX_RST;
		cfg_amp = AMP_RATIO_MIN_RST;
		held_valid = 1'b0;
		held_row = '0;
		row_taken = 1'b0;
		tx_idle_pct = 12;
		rx_idle_pct = 70;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Single-row tables at the field extremes, one with a negative length.
		queue_row(season_row(0, 0, 0, 0, 0, 0), 1'b1, 1'b0);
		queue_row(season_row(65535, 65535, 65535, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
			1'b1, 1'b0);
		queue_row(season_row(0, 65535, 0, 32'h80000000, 32'h80000000, 32'h80000000), 1'b1, 1'b0);
		queue_row(season_row(65535, 100, 0, 32'h80000000, 32'h7fffffff, 32'h80000000),
			1'b1, 1'b0);
		// Overlapping seasons cut at the lower trough.
		queue_row(season_row(100, 150, 250, 1000, 60000, 5000), 1'b0, 1'b0);
		queue_row(season_row(200, 260, 350, 3000, 50000, 2000), 1'b1, 1'b0);
		// Low second season pushed back to the earlier begin.
		queue_row(season_row(100, 150, 200, 0, 65536, 1000), 1'b0, 1'b0);
		queue_row(season_row(250, 260, 300, 2000, 2100, 0), 1'b1, 1'b0);
		// High trough merge, then a row that is not compared, then a normal pair.
		queue_row(season_row(0, 50, 100, 0, 65536, 60000), 1'b0, 1'b0);
		queue_row(season_row(120, 170, 250, 60000, 70000, 0), 1'b0, 1'b0);
		queue_row(season_row(300, 350, 400, 0, 50000, 0), 1'b0, 1'b1);
		queue_row(season_row(410, 450, 500, 40000, 60000, 100), 1'b1, 1'b0);
		// Zero gap with the span at its limit, merged on the last row.
		queue_row(season_row(0, 100, 200, 0, 65536, 50000), 1'b0, 1'b0);
		queue_row(season_row(200, 400, 650, 50000, 65536, 0), 1'b1, 1'b0);
		// Gap exactly at the close limit, and just past it with a wide span.
		queue_row(season_row(0, 50, 100, 0, 65536, 60000), 1'b0, 1'b0);
		queue_row(season_row(250, 300, 400, 60000, 70000, 0), 1'b1, 1'b0);
		queue_row(season_row(0, 50, 100, 0, 65536, 60000), 1'b0, 1'b0);
		queue_row(season_row(251, 300, 651, 60000, 70000, 0), 1'b1, 1'b0);
		// Peaks below the troughs give a negative amplitude.
		queue_row(season_row(0, 10, 20, 100000, -100000, 100000), 1'b0, 1'b0);
		queue_row(season_row(30, 40, 50, 100000, -200000, 90000), 1'b1, 1'b0);
		// Merge through the left slope test.
		queue_row(season_row(0, 50, 100, 0, 65536, 65000), 1'b0, 1'b0);
		queue_row(season_row(110, 150, 200, 10000, 100000, 0), 1'b1, 1'b0);
		// Push back followed by a merge through the right slope test.
		queue_row(season_row(0, 50, 100, 0, 100000, 10000), 1'b0, 1'b0);
		queue_row(season_row(110, 150, 200, 20000, 20500, 0), 1'b1, 1'b0);
		wait_quiet();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p == 2) begin
				tx_idle_pct = 70;
				rx_idle_pct = 12;
			end else if (p == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (p)
				0: set_ratios(1'b1, 16'd65535, 16'd0);
				1: set_ratios(1'b0, 16'($urandom()), 16'($urandom()));
				2: set_ratios(1'b1, 16'd0, 16'd65535);
				3: set_ratios(1'b1, 16'($urandom_range(20000, 60000)),
					16'($urandom_range(0, 8000)));
				4: set_ratios(1'b1, 16'($urandom()), 16'($urandom()));
				default: begin
					write_reg(REG_SPARE, $urandom());
					set_ratios(1'b1, TROUGH_RATIO_MAX_RST, AMP_RATIO_MIN_RST);
				end
			endcase
			phase_rows = 0;
			while (phase_rows < PHASE_ROWS) begin
				n = $urandom_range(1, 10);
				if ($urandom_range(0, 99) < 15)
					queue_noise_rows(n);
				else
					queue_season_table(n);
				phase_rows += n;
			end
			wait_quiet();
		end

		$display("Covered %0d rows in %0d tables, %0d result words, %0d merges.",
			rows_accepted, tables_seen, results_seen, absorbed_seen);
		$display("Register writes: %0d over %0d settings and three idling patterns.",
			cfg_writes, PHASE_COUNT + 1);
		if (err_count == 0)
			$display("[season_row_overlap_merge_core] OK");
		else
			$display("[season_row_overlap_merge_core] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/srom_pkg.sv
rtl/core/season_row_overlap_merge_core.sv
tb/tb.sv
